/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, pre, con, msg)
`define ASSERT_NEXT(lbl, pre, con, msg)
`endif
`endif

/* design/hvn_pkg.sv */
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types and constants of the heightmap vertex/normal generator.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int HW     = 16;   // sample width
  localparam int SW     = 33;   // squared length dx^2 + dz^2 + 4
  localparam int QW     = 33;   // normalised quotient, up to 2^32
  localparam int RTW    = 17;   // square root of the quotient
  localparam int TEX_LB = 16;   // fraction bits of the texture quotient
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd256;
  localparam logic [16:0]      NORM_MAX  = 17'd32767;
  localparam logic [16:0]      TEX_ONE   = 17'h10000;
  localparam logic [SW-1:0]    Y_SQ      = 33'd4;

  typedef enum logic [1:0] {
    REG_GRID_SIZE     = 2'd0,
    REG_HEIGHT_EXTENT = 2'd1,
    REG_WIDTH_EXTENT  = 2'd2
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_DIV  = 6'b010000,
    S_ROOT = 6'b100000
  } state_t;

endpackage

/* design/hvn_line_store.sv */
// ----------------------------------------------------------------------------
// hvn_line_store
// Two row buffers: previous row (two read ports) and the row before it.
// ----------------------------------------------------------------------------
module hvn_line_store
  import hvn_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_nx,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [HW-1:0]            wr_prev,
  input  logic [HW-1:0]            wr_prev2,
  output logic [HW-1:0]            prev_q,
  output logic [HW-1:0]            prev_nx_q,
  output logic [HW-1:0]            prev2_q
);

  logic [HW-1:0] prev_mem  [DEPTH];
  logic [HW-1:0] prev2_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr] <= wr_prev;
    end
    prev_q    <= prev_mem[rd_addr];
    prev_nx_q <= prev_mem[rd_addr_nx];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev2_mem[wr_addr] <= wr_prev2;
    end
    prev2_q <= prev2_mem[rd_addr];
  end

endmodule

/* design/hvn_div.sv */
// ----------------------------------------------------------------------------
// hvn_div
// Restoring divider, one quotient bit per cycle. rem0 must be <= divisor.
// ----------------------------------------------------------------------------
module hvn_div #(
  parameter int DW = 33,
  parameter int LB = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem0,
  input  logic [LB-1:0] low,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [LB:0]   quo
);

  localparam int CNTW = $clog2(LB + 2);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r, div_r, rem_nxt;
  logic [LB-1:0]   low_r;
  logic [LB:0]     quo_r;
  logic            first;
  logic [DW:0]     trial, diff;
  logic            ge;

  always_comb begin
    first   = (cnt_r == CNTW'(LB + 1));
    trial   = first ? {1'b0, rem_r} : {rem_r, low_r[LB-1]};
    ge      = (trial >= {1'b0, div_r});
    diff    = trial - {1'b0, div_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(LB + 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      low_r <= low;
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[LB-1:0], ge};
      if (!first) begin
        low_r <= low_r << 1;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* design/hvn_isqrt.sv */
// ----------------------------------------------------------------------------
// hvn_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module hvn_isqrt
  import hvn_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [QW-1:0]  radicand,
  output logic           busy,
  output logic [RTW-1:0] root
);

  logic          busy_r;
  logic [QW-1:0] m_r, res_r, bit_r;
  logic [QW:0]   sum;
  logic          ge;

  always_comb begin
    sum = {1'b0, res_r} + {1'b0, bit_r};
    ge  = ({1'b0, m_r} >= sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= radicand;
      res_r <= '0;
      bit_r <= QW'(1) << (QW - 1);
    end else if (busy_r) begin
      if (ge) begin
        m_r   <= QW'({1'b0, m_r} - sum);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[RTW-1:0];

endmodule

/* design/heightmap_vertex_normal_gen.sv */
// Sequence: a word that yields a vertex passes the load, multiply and sum
// states, then the divide and the square root, and is then registered to the output.
// Flow: one word at a time; a word with no vertex goes back to idle after the
// load state, a dropped word leaves the state idle; a stalled output holds the input.
// Reset (rst_n, synchronous, active low) clears counters and config to 256;
// line buffers are not cleared.
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_gen
// Streams an N x N heightmap and emits vertices with central-difference
// normals and texture coordinates, one row behind the input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heightmap_vertex_normal_gen
  import hvn_pkg::*;
#(
  parameter int MAX_GRID = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             in_sample_height,
  input  logic                    in_flush,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [9:0]              out_vert_row,
  output logic [9:0]              out_vert_col,
  output logic signed [11:0]      out_pos_x,
  output logic signed [16:0]      out_pos_y,
  output logic signed [11:0]      out_pos_z,
  output logic [15:0]             out_tex_u,
  output logic [16:0]             out_tex_v,
  output logic signed [15:0]      out_normal_x,
  output logic [14:0]             out_normal_y,
  output logic signed [15:0]      out_normal_z,
  output logic                    out_interior,
  output logic                    out_last_vertex
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int NW = CW + 1;
  localparam int EW = (NW + 2 > 13) ? NW + 2 : 13;
  localparam int TW = NW + 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] grid_r, hext_r, wext_r;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             wrap, drain, take;

  logic [HW-1:0]    s_r, h_r, left_r;
  logic             drain_r, produce_r, inner_r, last_r;
  logic [NW-1:0]    vrow_r;
  logic [CW-1:0]    vcol_r, addr_r, addr_nx;
  logic signed [16:0] dx_r, dz_r;
  logic [31:0]      sqx_r, sqz_r;
  logic signed [33:0] px, pz;

  logic [HW-1:0]    prev_q, prev_nx_q, prev2_q, right;

  logic             div_start, root_start, div_busy, root_busy, load_out;
  logic [2:0]       nd_busy, rt_busy;
  logic [1:0]       td_busy;
  logic [SW-1:0]    nd_rem0 [3];
  logic [SW-1:0]    s_len;
  logic [QW-1:0]    nd_quo [3];
  logic [RTW-1:0]   root [3];
  logic [TEX_LB:0]  qu, qv;
  logic [16:0]      mag [3];
  logic [17:0]      rnd [3];
  logic [16:0]      negm [2];
  logic [15:0]      nx_v, nz_v;
  logic [14:0]      ny_v;
  logic [EW-1:0]    posx_w, posz_w;
  logic             out_valid_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= CFG_RESET;
      hext_r <= CFG_RESET;
      wext_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_SIZE:     grid_r <= cfg_wdata;
        REG_HEIGHT_EXTENT: hext_r <= cfg_wdata;
        REG_WIDTH_EXTENT:  wext_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  always_comb begin
    if (grid_r < CFG_W'(2)) begin
      n_eff = NW'(2);
    end else if (int'(grid_r) > MAX_GRID) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(grid_r);
    end
  end

  // ---------------- raster position ----------------
  assign in_ready = (state_r == S_IDLE);
  assign wrap     = (NW'(col_r) >= n_eff - NW'(1));
  assign drain    = (row_r >= n_eff);
  // a flush outside the drain phase, or a sample inside it, is dropped
  assign take     = in_valid && in_ready && (drain ? in_flush : !in_flush);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (take) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = drain ? '0 : row_r + NW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_r       <= in_sample_height;
      drain_r   <= drain;
      produce_r <= drain || (row_r != '0);
      vrow_r    <= drain ? n_eff - NW'(1) : row_r - NW'(1);
      vcol_r    <= col_r;
      addr_r    <= col_r;
      last_r    <= drain && wrap;
      inner_r   <= !drain && (row_r >= NW'(2))
                   && ((NW + 1)'(row_r) + (NW + 1)'(1) <= (NW + 1)'(n_eff))
                   && (col_r != '0)
                   && ((NW + 1)'(col_r) + (NW + 1)'(2) <= (NW + 1)'(n_eff));
    end
  end

  // ---------------- line buffers ----------------
  assign addr_nx = (int'(col_r) == MAX_GRID - 1) ? '0 : col_r + CW'(1);
  assign right   = (int'(addr_r) == MAX_GRID - 1) ? '0 : prev_nx_q;

  hvn_line_store #(.DEPTH(MAX_GRID)) u_store (
    .clk        (clk),
    .rd_addr    (col_r),
    .rd_addr_nx (addr_nx),
    .wr_en      (state_r == S_LOAD && !drain_r),
    .wr_addr    (addr_r),
    .wr_prev    (s_r),
    .wr_prev2   (prev_q),
    .prev_q     (prev_q),
    .prev_nx_q  (prev_nx_q),
    .prev2_q    (prev2_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (state_r == S_LOAD) begin
      left_r <= prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      h_r  <= prev_q;
      dx_r <= $signed({1'b0, prev2_q}) - $signed({1'b0, s_r});
      dz_r <= $signed({1'b0, left_r}) - $signed({1'b0, right});
    end
    if (state_r == S_MUL) begin
      sqx_r <= px[31:0];
      sqz_r <= pz[31:0];
    end
  end

  assign px = dx_r * dx_r;
  assign pz = dz_r * dz_r;

  // ---------------- sequencer ----------------
  assign div_busy   = (|nd_busy) || (|td_busy);
  assign root_busy  = |rt_busy;
  assign div_start  = (state_r == S_SUM);
  assign root_start = (state_r == S_DIV) && !div_busy;
  assign load_out   = (state_r == S_ROOT) && !root_busy && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (take) state_nxt = S_LOAD;
      S_LOAD: state_nxt = produce_r ? S_MUL : S_IDLE;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  if (!div_busy) state_nxt = S_ROOT;
      S_ROOT: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- normal lanes: a^2 * 2^32 / S, then root ----------------
  assign s_len      = SW'(sqx_r) + SW'(sqz_r) + Y_SQ;
  assign nd_rem0[0] = SW'(sqx_r);
  assign nd_rem0[1] = Y_SQ;
  assign nd_rem0[2] = SW'(sqz_r);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    hvn_div #(.DW(SW), .LB(QW - 1)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (div_start),
      .rem0    (nd_rem0[i]),
      .low     ('0),
      .divisor (s_len),
      .busy    (nd_busy[i]),
      .quo     (nd_quo[i])
    );
    hvn_isqrt u_root (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (root_start),
      .radicand (nd_quo[i]),
      .busy     (rt_busy[i]),
      .root     (root[i])
    );
  end

  // ---------------- texture: (k * 2^17 + N) / 2N ----------------
  hvn_div #(.DW(TW), .LB(TEX_LB)) u_tex_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .rem0    ({1'b0, vcol_r, 1'b0}),
    .low     (TEX_LB'(n_eff)),
    .divisor ({n_eff, 1'b0}),
    .busy    (td_busy[0]),
    .quo     (qu)
  );

  hvn_div #(.DW(TW), .LB(TEX_LB)) u_tex_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .rem0    ({vrow_r, 1'b0}),
    .low     (TEX_LB'(n_eff)),
    .divisor ({n_eff, 1'b0}),
    .busy    (td_busy[1]),
    .quo     (qv)
  );

  // ---------------- result assembly ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, root[i]} + 18'd1;
      mag[i] = rnd[i][17:1];
    end
    negm[0] = 17'd0 - mag[0];
    negm[1] = 17'd0 - mag[2];
    if (!inner_r) begin
      nx_v = '0;
      ny_v = '0;
      nz_v = '0;
    end else begin
      if (dx_r[16]) nx_v = negm[0][15:0];
      else          nx_v = (mag[0] > NORM_MAX) ? NORM_MAX[15:0] : mag[0][15:0];
      ny_v = (mag[1] > NORM_MAX) ? NORM_MAX[14:0] : mag[1][14:0];
      if (dz_r[16]) nz_v = negm[1][15:0];
      else          nz_v = (mag[2] > NORM_MAX) ? NORM_MAX[15:0] : mag[2][15:0];
    end
    posx_w = (EW'(vrow_r) << 1) - EW'(hext_r);
    posz_w = (EW'(vcol_r) << 1) - EW'(wext_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_vert_row    <= 10'(vrow_r);
      out_vert_col    <= 10'(vcol_r);
      out_pos_x       <= posx_w[11:0];
      out_pos_y       <= 17'd0 - {1'b0, h_r};
      out_pos_z       <= posz_w[11:0];
      out_tex_u       <= qu[15:0];
      out_tex_v       <= TEX_ONE - qv;
      out_normal_x    <= nx_v;
      out_normal_y    <= ny_v;
      out_normal_z    <= nz_v;
      out_interior    <= inner_r;
      out_last_vertex <= last_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- checks ----------------
  `ASSERT_IMPL(a_root_after_div, state_r == S_ROOT, !div_busy, "root stage while dividing")
  `ASSERT_NEXT(a_root_started, root_start, root_busy, "root lanes did not start")
  `ASSERT_IMPL(a_border_zero, out_valid_r && !out_interior, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0, "border vertex with normal")
  `ASSERT_IMPL(a_inner_up, out_valid_r && out_interior, out_normal_y != '0 && !out_last_vertex, "interior normal has no up part")

endmodule
